// ===== hw/rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Beat types, decoded command entry and character codes shared by the blocks.
// ----------------------------------------------------------------------------
package upd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // One decoded input beat: one to three bytes, emitted from index 0 upward.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

endpackage

// ===== hw/rtl/upd_front.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts encoded beats, tracks the escape phase and builds command entries.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  upd_pkg::in_beat_t item,
  input  logic             q_full,
  output logic             full,
  output logic             enq,
  output upd_pkg::cmd_t    cmd
);

  upd_pkg::phase_t phase;
  upd_pkg::phase_t phase_next;
  logic [7:0]      held_digit;
  logic [7:0]      held_digit_next;
  logic            accept;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    hex_value = (c inside {[8'h30:8'h39]}) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digit <= held_digit_next;
    end
  end

  always_comb begin
    logic       hex;
    logic       fr_emit;
    logic [7:0] fr_byte;
    upd_pkg::phase_t fr_phase;
    hex = is_hex(item.in_byte);
    // Decoding of the beat as if no escape were pending.
    fr_emit  = 1'b1;
    fr_phase = upd_pkg::PH_IDLE;
    fr_byte  = item.in_byte;
    if (item.in_byte == upd_pkg::CH_PERCENT) begin
      if (!item.in_last) begin
        fr_emit  = 1'b0;
        fr_phase = upd_pkg::PH_PCT;
      end
    end else if (item.in_byte == upd_pkg::CH_PLUS) begin
      fr_byte = upd_pkg::CH_SPACE;
    end

    phase_next      = fr_phase;
    held_digit_next = held_digit;
    cmd.last        = item.in_last;
    cmd.bytes       = '0;
    cmd.cnt         = 2'd0;
    case (phase)
      upd_pkg::PH_PCT: begin
        cmd.bytes[0] = upd_pkg::CH_PERCENT;
        if (hex && item.in_last) begin
          cmd.bytes[1] = item.in_byte;
          cmd.cnt      = 2'd2;
          phase_next   = upd_pkg::PH_IDLE;
        end else if (hex) begin
          held_digit_next = item.in_byte;
          phase_next      = upd_pkg::PH_DIGIT;
        end else begin
          cmd.bytes[1] = fr_byte;
          cmd.cnt      = fr_emit ? 2'd2 : 2'd1;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (hex) begin
          cmd.bytes[0] = {hex_value(held_digit), hex_value(item.in_byte)};
          cmd.cnt      = 2'd1;
          phase_next   = upd_pkg::PH_IDLE;
        end else begin
          cmd.bytes[0] = upd_pkg::CH_PERCENT;
          cmd.bytes[1] = held_digit;
          cmd.bytes[2] = fr_byte;
          cmd.cnt      = fr_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        cmd.bytes[0] = fr_byte;
        cmd.cnt      = fr_emit ? 2'd1 : 2'd0;
      end
    endcase
    enq = accept && (cmd.cnt != 2'd0);
  end

endmodule

// ===== hw/rtl/upd_queue.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  upd_pkg::cmd_t wdata,
  input  logic          rd,
  output upd_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/upd_back.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Serializes command entries into decoded bytes through an output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  upd_pkg::cmd_t      cmd,
  output logic               deq,
  input  logic               pop,
  output logic               empty,
  output upd_pkg::out_beat_t result
);

  logic [1:0] idx;
  logic       valid;
  logic       load;
  logic       final_byte;

  assign empty      = !valid;
  assign load       = !q_empty && (!valid || pop);
  assign final_byte = (idx == cmd.cnt - 2'd1);
  assign deq        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx   <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= cmd.bytes[idx];
      result.out_last <= cmd.last && final_byte;
    end
  end

endmodule

// ===== hw/rtl/url_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder core
// Path: an input beat is accepted while the queue is not full and written into
// a queue entry; its decoded bytes go from there into the output register when it is free.
// Throughput: one input beat per cycle while the queue is not full and each
// beat yields at most one byte; the back end emits one byte per cycle unless
// pop stalls it; the queue absorbs the up to three bytes of an escape flush.
// Reset: synchronous rst empties the queue and output register and clears
// any pending escape.
// ----------------------------------------------------------------------------
module url_percent_decoder_core #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_beat_t  item,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_beat_t result
);

  upd_pkg::cmd_t enq_cmd;
  upd_pkg::cmd_t head_cmd;
  logic          enq;
  logic          deq;
  logic          q_full;
  logic          q_empty;

  upd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .full   (full),
    .enq    (enq),
    .cmd    (enq_cmd)
  );

  upd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (enq),
    .wdata (enq_cmd),
    .rd    (deq),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  upd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .cmd     (head_cmd),
    .deq     (deq),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== hw/rtl/upd_checker.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder port checker
// Watches the queue-style ports of the core over time.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input upd_pkg::out_beat_t result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // Reset leaves room for the next beat.
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_result_stays: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("waiting result changed");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== test/tb_url_percent_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// URL percent decoder core testbench
// Sends encoded strings through the core in bursts while the result side
// stalls on its own pattern. Each accepted beat is decoded again here and
// every result beat is checked against the oldest decoded byte waiting.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BEATS   = 270;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  typedef struct {
    upd_pkg::in_beat_t beat;
    bit                drain_first;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  upd_pkg::in_beat_t  item = '0;
  logic               empty;
  logic               pop = 1'b0;
  upd_pkg::out_beat_t result;

  pending_t           encoded_q[$];
  upd_pkg::out_beat_t decoded_q[$];

  upd_pkg::phase_t esc_phase = upd_pkg::PH_IDLE;
  logic [7:0]      held_digit = '0;

  int                 beats_total = 0;
  int                 beats_taken = 0;
  int                 err_cnt = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 idle_cnt = 0;
  logic [15:0]        stall_pat = '1;
  int                 stall_idx = 0;
  pending_t           next_beat;
  upd_pkg::out_beat_t want;

  url_percent_decoder_core uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_F);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 4'(c - CH_UPPER_A + 8'd10);
    return 4'(c - CH_LOWER_A + 8'd10);
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic l);
    upd_pkg::out_beat_t o;
    o.out_byte = b;
    o.out_last = l;
    decoded_q.insert(decoded_q.size(), o);
  endfunction

  // Decoding of a byte when no escape is pending.
  function automatic void decode_plain(logic [7:0] b, logic l);
    if (b == upd_pkg::CH_PERCENT) begin
      if (l) begin
        esc_phase = upd_pkg::PH_IDLE;
        expect_byte(upd_pkg::CH_PERCENT, 1'b1);
      end else begin
        esc_phase = upd_pkg::PH_PCT;
      end
    end else begin
      esc_phase = upd_pkg::PH_IDLE;
      expect_byte((b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b, l);
    end
  endfunction

  function automatic void decode_beat(upd_pkg::in_beat_t b);
    case (esc_phase)
      upd_pkg::PH_PCT: begin
        if (is_hex_char(b.in_byte)) begin
          if (b.in_last) begin
            esc_phase = upd_pkg::PH_IDLE;
            expect_byte(upd_pkg::CH_PERCENT, 1'b0);
            expect_byte(b.in_byte, 1'b1);
          end else begin
            held_digit = b.in_byte;
            esc_phase = upd_pkg::PH_DIGIT;
          end
        end else begin
          expect_byte(upd_pkg::CH_PERCENT, 1'b0);
          decode_plain(b.in_byte, b.in_last);
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (is_hex_char(b.in_byte)) begin
          esc_phase = upd_pkg::PH_IDLE;
          expect_byte({hex_nibble(held_digit), hex_nibble(b.in_byte)}, b.in_last);
        end else begin
          expect_byte(upd_pkg::CH_PERCENT, 1'b0);
          expect_byte(held_digit, 1'b0);
          decode_plain(b.in_byte, b.in_last);
        end
      end
      default: decode_plain(b.in_byte, b.in_last);
    endcase
  endfunction

  function automatic void add_beat(logic [7:0] b, logic l, bit hold);
    pending_t p;
    p.beat.in_byte = b;
    p.beat.in_last = l;
    p.drain_first = hold;
    encoded_q.insert(encoded_q.size(), p);
    beats_total++;
  endfunction

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_ZERO + 8'(k);
    if (k < 16) return CH_LOWER_A + 8'(k - 10);
    return CH_UPPER_A + 8'(k - 16);
  endfunction

  // Any byte that is not a hex digit, often one next to a hex range.
  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: return CH_ZERO - 8'd1;
      1: return CH_NINE + 8'd1;
      2: return CH_UPPER_A - 8'd1;
      3: return CH_UPPER_F + 8'd1;
      4: return CH_LOWER_A - 8'd1;
      5: return CH_LOWER_F + 8'd1;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (is_hex_char(c)) c = 8'($urandom_range(0, 255));
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    c = rand_nonhex();
    while (c == upd_pkg::CH_PERCENT || c == upd_pkg::CH_PLUS) c = rand_nonhex();
    return c;
  endfunction

  function automatic void add_string(bit hold);
    logic [7:0] sym[$];
    int n;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin
      repeat (n) sym.insert(sym.size(), 8'($urandom_range(0, 255)));
    end else begin
      repeat (n) begin
        case ($urandom_range(0, 9))
          3: sym.insert(sym.size(), upd_pkg::CH_PLUS);
          4, 5, 6: begin
            sym.insert(sym.size(), upd_pkg::CH_PERCENT);
            sym.insert(sym.size(), rand_hex());
            sym.insert(sym.size(), rand_hex());
          end
          7: begin
            sym.insert(sym.size(), upd_pkg::CH_PERCENT);
            sym.insert(sym.size(), rand_nonhex());
          end
          8: begin
            sym.insert(sym.size(), upd_pkg::CH_PERCENT);
            sym.insert(sym.size(), rand_hex());
            sym.insert(sym.size(), rand_nonhex());
          end
          9: begin
            sym.insert(sym.size(), upd_pkg::CH_PERCENT);
            if ($urandom_range(0, 1) == 1) sym.insert(sym.size(), rand_hex());
          end
          default: sym.insert(sym.size(), rand_plain());
        endcase
      end
    end
    foreach (sym[k]) add_beat(sym[k], k == sym.size() - 1, hold && k == 0);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_beat(item);
        beats_taken++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (encoded_q.size() == 0 ||
                     (encoded_q[0].drain_first && decoded_q.size() != 0)) begin
          push <= 1'b0;
        end else begin
          next_beat = encoded_q.pop_front();
          item <= next_beat.beat;
          push <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                                                      $urandom_range(0, 2);
          end
        end
      end
    end
  end

  // Receiver: pops on a 16-bit stall pattern that is redrawn each time it runs out.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected beat: out_byte=%02h out_last=%0d",
                 result.out_byte, result.out_last);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, result.out_byte);
            err_cnt++;
          end
          if (result.out_last !== want.out_last) begin
            $error("out_last: expected %0d, actual %0d", want.out_last, result.out_last);
            err_cnt++;
          end
        end
      end
      pop <= stall_pat[stall_idx];
      if (stall_idx == 15) begin
        stall_idx = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end else begin
        stall_idx++;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    // Edges of the byte range, plus, and a percent sign alone at the end.
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(upd_pkg::CH_PLUS, 1'b1, 1'b0);
    add_beat(upd_pkg::CH_PERCENT, 1'b1, 1'b0);
    // A full escape with mixed case, ending the string.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_LOWER_A, 1'b0, 1'b0);
    add_beat(CH_UPPER_F, 1'b1, 1'b0);
    // Percent and one digit cut off by the end of the string.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_ZERO + 8'd7, 1'b1, 1'b0);
    // A non-hex byte right after the percent sign.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_LOWER_F + 8'd1, 1'b0, 1'b0);
    // A second percent sign restarts the escape.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_NINE, 1'b0, 1'b0);
    add_beat(CH_ZERO, 1'b0, 1'b0);
    // A non-hex byte after percent and digit, then a flush of three bytes.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_UPPER_A + 8'd1, 1'b0, 1'b0);
    add_beat(upd_pkg::CH_PLUS, 1'b1, 1'b0);
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(CH_LOWER_A + 8'd2, 1'b0, 1'b0);
    add_beat(upd_pkg::CH_PERCENT, 1'b1, 1'b0);
    // A high byte is never a hex digit.
    add_beat(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_beat(8'h80, 1'b1, 1'b0);

    add_string(1'b1);
    while (beats_total < RANDOM_BEATS) add_string($urandom_range(0, 11) == 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (beats_taken < beats_total) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/upd_pkg.sv
hw/rtl/upd_front.sv
hw/rtl/upd_queue.sv
hw/rtl/upd_back.sv
hw/rtl/url_percent_decoder_core.sv
hw/rtl/upd_checker.sv
test/tb_url_percent_decoder_core.sv
